### src/dra_pkg.sv
// Shared constants and types for the damage rectangle accumulator.
package dra_pkg;
  localparam int unsigned MaxRectsDefault = 8;
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_MARK  = 2'd2,
    OP_LIST  = 2'd3
  } opcode_e;
  typedef enum logic [1:0] {
    REG_VP_X = 2'd0,
    REG_VP_Y = 2'd1,
    REG_VP_W = 2'd2,
    REG_VP_H = 2'd3
  } reg_idx_e;
  // Stored rectangle: coordinates 16-bit signed, extents 17-bit unsigned.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [16:0]        w;
    logic [16:0]        h;
  } rect_t;
  localparam logic [31:0] AreaMax = 32'hFFFF_FFFF;
endpackage

### src/damage_rect_accumulator_top.sv
// Top level of the damage rectangle accumulator: sequencer, entry store and APB registers.
// Sequencing: clear and mark go straight to the bounds pass, an empty list answers directly; a
//   list reads each entry before its beat; the bounds pass reads every entry, then clips; add
//   scans entries (one shared 17x17 multiplier); if none contains it, commits; then bounds.
// Throughput: one item at a time; s_axis_tready is low until the last result beat is taken.
// Reset: rst_ni (async, low) clears count, flags, area, viewport and control; no store reset.
module damage_rect_accumulator_top import dra_pkg::*; #(
  parameter int unsigned MAX_RECTS = MaxRectsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: opcode[1:0], rect_x[17:2], rect_y[33:18], rect_w[49:34], rect_h[65:50], zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_x[15:0], out_y[31:16], out_w[48:32], out_h[65:49], all_damaged[66],
  //        rect_count[70:67], rect_valid[71]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IdxW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_A, S_SCAN_B, S_SCAN_C, S_PICK, S_INSERT, S_MERGE_RD,
    S_MERGE, S_AREA, S_COLLAPSE, S_BOUNDS, S_BND_RD, S_BND, S_CLIP, S_LIST_RD, S_LIST,
    S_OUT
  } state_e;

  // viewport registers
  logic signed [15:0] vp_x_q, vp_y_q, vp_w_q, vp_h_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q <= '0; vp_y_q <= '0; vp_w_q <= '0; vp_h_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_VP_X: vp_x_q <= pwdata[15:0];
        REG_VP_Y: vp_y_q <= pwdata[15:0];
        REG_VP_W: vp_w_q <= pwdata[15:0];
        REG_VP_H: vp_h_q <= pwdata[15:0];
        default:  ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_VP_X: prdata = {{16{vp_x_q[15]}}, vp_x_q};
      REG_VP_Y: prdata = {{16{vp_y_q[15]}}, vp_y_q};
      REG_VP_W: prdata = {{16{vp_w_q[15]}}, vp_w_q};
      REG_VP_H: prdata = {{16{vp_h_q[15]}}, vp_h_q};
      default:  prdata = '0;
    endcase
  end

  rect_t mem_q [MAX_RECTS];
  rect_t ent_q;            // registered read data
  logic [IdxW-1:0] rd_idx;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  rect_t           wr_data;
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_data;
    ent_q <= mem_q[rd_idx];
  end

  state_e state_q;
  logic signed [15:0] rx_q, ry_q;
  logic [16:0] rw_q, rh_q;          // positive once an add goes past the empty check
  logic [CntW-1:0] cnt_q, i_q;
  logic all_q;
  logic [31:0] area_q;
  // scan results
  logic [16:0] uw_q, uh_q;          // union extents for the current entry
  logic [33:0] ua_q, ea_q, ra_q;    // union, entry, new-rect areas
  logic zf_q, bv_q;                 // zero-waste entry seen, best entry valid
  logic [IdxW-1:0] zi_q, best_q;
  logic signed [36:0] zw_q, best_w_q, mw_q;
  // bounds accumulation (18-bit signed edges)
  logic signed [17:0] bx0_q, by0_q, bx1_q, by1_q;
  // output register
  logic ov_q, olast_q, ovalid_q;
  logic signed [15:0] ox_q, oy_q;
  logic [16:0] ow_q, oh_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {ovalid_q, 4'(cnt_q), all_q, oh_q, ow_q, oy_q, ox_q};

  // union of current entry and new rect (adds and compares only)
  logic signed [17:0] e_r, e_b, n_r, n_b, u_x, u_y, u_r, u_b, uw_c, uh_c;
  always_comb begin
    e_r  = 18'(ent_q.x) + $signed({1'b0, ent_q.w});
    e_b  = 18'(ent_q.y) + $signed({1'b0, ent_q.h});
    n_r  = 18'(rx_q) + $signed({1'b0, rw_q});
    n_b  = 18'(ry_q) + $signed({1'b0, rh_q});
    u_x  = (ent_q.x < rx_q) ? 18'(ent_q.x) : 18'(rx_q);
    u_y  = (ent_q.y < ry_q) ? 18'(ent_q.y) : 18'(ry_q);
    u_r  = (e_r > n_r) ? e_r : n_r;
    u_b  = (e_b > n_b) ? e_b : n_b;
    uw_c = u_r - u_x;
    uh_c = u_b - u_y;
  end
  logic contains;
  assign contains = (rx_q >= ent_q.x) && (ry_q >= ent_q.y) && (n_r <= e_r) && (n_b <= e_b);

  logic [15:0] vwp, vhp;
  assign vwp = vp_w_q[15] ? 16'd0 : vp_w_q;
  assign vhp = vp_h_q[15] ? 16'd0 : vp_h_q;

  // the one multiplier: new rect on accept, entry and union during the scan,
  // viewport for the collapse test
  logic [16:0] ma, mb;
  logic [33:0] mp;
  always_comb begin
    case (state_q)
      S_IDLE:   begin ma = {1'b0, s_axis_tdata[49:34]}; mb = {1'b0, s_axis_tdata[65:50]}; end
      S_SCAN_A: begin ma = ent_q.w; mb = ent_q.h; end
      S_SCAN_B: begin ma = uw_q; mb = uh_q; end
      default:  begin ma = {1'b0, vwp}; mb = {1'b0, vhp}; end
    endcase
    mp = ma * mb;
  end

  // merge waste of the current entry
  logic signed [36:0] wst;
  assign wst = $signed({3'b0, ua_q}) - $signed({3'b0, ea_q}) - $signed({3'b0, ra_q});

  // area increment (waste + new area), saturating at AreaMax
  logic signed [37:0] inc, asum;
  logic [31:0] anext;
  always_comb begin
    inc  = 38'(mw_q) + $signed({4'b0, ra_q});
    asum = $signed({6'b0, area_q}) + inc;
    if (inc <= 38'sd0) anext = area_q;
    else if (asum > $signed({6'b0, AreaMax})) anext = AreaMax;
    else anext = asum[31:0];
  end

  logic collapse;
  assign collapse = (mp != '0) && ({1'b0, area_q, 1'b0} >= mp);

  // clip signals
  logic signed [17:0] vr, vb, cx0, cy0, cx1, cy1, cw, ch;
  always_comb begin
    vr  = 18'(vp_x_q) + 18'(vp_w_q);
    vb  = 18'(vp_y_q) + 18'(vp_h_q);
    cx0 = (bx0_q > 18'(vp_x_q)) ? bx0_q : 18'(vp_x_q);
    cy0 = (by0_q > 18'(vp_y_q)) ? by0_q : 18'(vp_y_q);
    cx1 = (vr < bx1_q) ? vr : bx1_q;
    cy1 = (vb < by1_q) ? vb : by1_q;
    cw  = cx1 - cx0;
    ch  = cy1 - cy0;
  end

  logic [CntW-1:0] nxt_i;
  assign nxt_i = i_q + CntW'(1);

  always_comb begin
    wr_en = 1'b0;
    wr_idx = i_q[IdxW-1:0];
    wr_data = '{x: u_x[15:0], y: u_y[15:0], w: uw_c[16:0], h: uh_c[16:0]};
    rd_idx = i_q[IdxW-1:0];
    if (state_q == S_INSERT) begin
      wr_en = 1'b1;
      wr_idx = cnt_q[IdxW-1:0];
      wr_data = '{x: rx_q, y: ry_q, w: rw_q, h: rh_q};
    end else if (state_q == S_MERGE) begin
      wr_en = 1'b1;
    end
  end

  // output beat load
  logic ld_en, ld_valid, ld_last;
  logic signed [15:0] ld_x, ld_y;
  logic [16:0] ld_w, ld_h;
  always_comb begin
    ld_en = 1'b0; ld_valid = 1'b0; ld_last = 1'b1;
    ld_x = '0; ld_y = '0; ld_w = '0; ld_h = '0;
    case (state_q)
      S_IDLE: ld_en = s_axis_tvalid && (opcode_e'(s_axis_tdata[1:0]) == OP_LIST) &&
                      (cnt_q == '0);
      S_BOUNDS: begin
        if (all_q) begin
          ld_en = 1'b1;
          ld_x = vp_x_q; ld_y = vp_y_q; ld_w = {1'b0, vwp}; ld_h = {1'b0, vhp};
          ld_valid = (vwp != '0) && (vhp != '0);
        end else if (cnt_q == '0) begin
          ld_en = 1'b1;
        end
      end
      S_CLIP: begin
        ld_en = 1'b1;
        if (cw > 18'sd0 && ch > 18'sd0) begin
          ld_x = cx0[15:0]; ld_y = cy0[15:0]; ld_w = cw[16:0]; ld_h = ch[16:0];
          ld_valid = 1'b1;
        end
      end
      S_LIST: begin
        ld_en = 1'b1;
        ld_x = ent_q.x; ld_y = ent_q.y; ld_w = ent_q.w; ld_h = ent_q.h;
        ld_valid = 1'b1;
        ld_last = (nxt_i == cnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; i_q <= '0; all_q <= 1'b0; area_q <= '0;
      rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0;
      uw_q <= '0; uh_q <= '0; ua_q <= '0; ea_q <= '0; ra_q <= '0;
      zf_q <= 1'b0; bv_q <= 1'b0; zi_q <= '0; best_q <= '0;
      zw_q <= '0; best_w_q <= '0; mw_q <= '0;
      bx0_q <= '0; by0_q <= '0; bx1_q <= '0; by1_q <= '0;
      ov_q <= 1'b0; olast_q <= 1'b0; ovalid_q <= 1'b0;
      ox_q <= '0; oy_q <= '0; ow_q <= '0; oh_q <= '0;
    end else begin
      if (ld_en) begin
        ov_q <= 1'b1; olast_q <= ld_last; ovalid_q <= ld_valid;
        ox_q <= ld_x; oy_q <= ld_y; ow_q <= ld_w; oh_q <= ld_h;
      end else if (state_q == S_OUT && m_axis_tready) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          rx_q <= s_axis_tdata[17:2];
          ry_q <= s_axis_tdata[33:18];
          rw_q <= {1'b0, s_axis_tdata[49:34]};
          rh_q <= {1'b0, s_axis_tdata[65:50]};
          ra_q <= mp;
          i_q  <= '0;
          zf_q <= 1'b0;
          bv_q <= 1'b0;
          case (opcode_e'(s_axis_tdata[1:0]))
            OP_CLEAR: begin
              cnt_q <= '0; all_q <= 1'b0; area_q <= '0; state_q <= S_BOUNDS;
            end
            OP_MARK: begin all_q <= 1'b1; state_q <= S_BOUNDS; end
            OP_LIST: state_q <= (cnt_q == '0) ? S_OUT : S_LIST_RD;
            OP_ADD: begin
              // ignored when everything is damaged or the rectangle is empty
              if (all_q || s_axis_tdata[49] || s_axis_tdata[65] ||
                  s_axis_tdata[49:34] == 16'd0 || s_axis_tdata[65:50] == 16'd0)
                state_q <= S_BOUNDS;
              else if (cnt_q == '0) state_q <= S_PICK;
              else state_q <= S_SCAN_RD;
            end
            default: ;
          endcase
        end
        // one pass: containment, then merge waste of each entry
        S_SCAN_RD: state_q <= S_SCAN_A;
        S_SCAN_A: begin
          uw_q <= uw_c[16:0];
          uh_q <= uh_c[16:0];
          ea_q <= mp;
          state_q <= contains ? S_BOUNDS : S_SCAN_B;
        end
        S_SCAN_B: begin
          ua_q <= mp;
          state_q <= S_SCAN_C;
        end
        S_SCAN_C: begin
          if (!zf_q && wst <= 37'sd0) begin
            zf_q <= 1'b1; zi_q <= i_q[IdxW-1:0]; zw_q <= wst;
          end
          if (!bv_q || wst < best_w_q) begin
            bv_q <= 1'b1; best_q <= i_q[IdxW-1:0]; best_w_q <= wst;
          end
          if (nxt_i == cnt_q) state_q <= S_PICK;
          else begin
            i_q <= nxt_i; state_q <= S_SCAN_RD;
          end
        end
        // first zero-waste entry, else a free slot, else the least-waste entry
        S_PICK: begin
          if (zf_q) begin
            i_q <= CntW'(zi_q); mw_q <= zw_q; state_q <= S_MERGE_RD;
          end else if (cnt_q < CntW'(MAX_RECTS)) begin
            mw_q <= '0; state_q <= S_INSERT;
          end else begin
            i_q <= CntW'(best_q); mw_q <= best_w_q; state_q <= S_MERGE_RD;
          end
        end
        S_INSERT: begin
          cnt_q <= cnt_q + CntW'(1);
          state_q <= S_AREA;
        end
        S_MERGE_RD: state_q <= S_MERGE;
        S_MERGE: state_q <= S_AREA;
        S_AREA: begin
          area_q <= anext;
          state_q <= S_COLLAPSE;
        end
        S_COLLAPSE: begin
          if (collapse) begin
            all_q <= 1'b1; cnt_q <= '0;
          end
          state_q <= S_BOUNDS;
        end
        S_BOUNDS: begin
          if (all_q || cnt_q == '0) state_q <= S_OUT;
          else begin
            i_q <= '0;
            bx0_q <= 18'sh1ffff; by0_q <= 18'sh1ffff;
            bx1_q <= {1'b1, 17'd0}; by1_q <= {1'b1, 17'd0};
            state_q <= S_BND_RD;
          end
        end
        S_BND_RD: state_q <= S_BND;
        S_BND: begin
          bx0_q <= (18'(ent_q.x) < bx0_q) ? 18'(ent_q.x) : bx0_q;
          by0_q <= (18'(ent_q.y) < by0_q) ? 18'(ent_q.y) : by0_q;
          bx1_q <= (e_r > bx1_q) ? e_r : bx1_q;
          by1_q <= (e_b > by1_q) ? e_b : by1_q;
          if (nxt_i == cnt_q) state_q <= S_CLIP;
          else begin
            i_q <= nxt_i; state_q <= S_BND_RD;
          end
        end
        S_CLIP: state_q <= S_OUT;
        S_LIST_RD: state_q <= S_LIST;
        S_LIST: state_q <= S_OUT;
        S_OUT: if (m_axis_tready) begin
          if (olast_q) state_q <= S_IDLE;
          else begin
            i_q <= nxt_i; state_q <= S_LIST_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/damage_rect_accumulator_top_tb.sv
// Self-checking testbench for the damage rectangle accumulator top level.
module damage_rect_accumulator_top_tb;
  import dra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = MaxRectsDefault;
  // Drain margin after the last beat.
  localparam int DrainCycles = 80;
  localparam int CycleLimit = 800000;

  // One expected output beat, at the port widths.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [16:0] w;
    logic [16:0] h;
    logic        all_dmg;
    logic [3:0]  cnt;
    logic        valid;
    logic        last;
  } dmg_beat_t;

  // Tracks the rectangle store and the expected output beats.
  class rect_scoreboard;
    longint ex[Slots], ey[Slots], ew[Slots], eh[Slots];
    int unsigned cnt;
    bit all_dmg;
    longint unsigned area;
    longint vx, vy, vw, vh;
    dmg_beat_t pending[$];
    int errors;

    function void set_reg(reg_idx_e idx, logic [15:0] v);
      longint s;
      s = longint'($signed(v));
      case (idx)
        REG_VP_X: vx = s;
        REG_VP_Y: vy = s;
        REG_VP_W: vw = s;
        default:  vh = s;
      endcase
    endfunction

    function longint area_of(longint w, longint h);
      if (w <= 0 || h <= 0) return 0;
      return w * h;
    endfunction

    function void bbox(input longint ax, ay, aw, ah, bx, by, bw, bh,
                       output longint ux, uy, uw, uh);
      longint ar, br, ab, bb;
      ar = ax + aw; br = bx + bw; ab = ay + ah; bb = by + bh;
      ux = ax < bx ? ax : bx;
      uy = ay < by ? ay : by;
      uw = (ar > br ? ar : br) - ux;
      uh = (ab > bb ? ab : bb) - uy;
    endfunction

    function longint waste(int i, longint x, y, w, h);
      longint ux, uy, uw, uh;
      bbox(ex[i], ey[i], ew[i], eh[i], x, y, w, h, ux, uy, uw, uh);
      return area_of(uw, uh) - area_of(ew[i], eh[i]) - area_of(w, h);
    endfunction

    function void grow_area(longint d);
      longint unsigned s;
      if (d <= 0) return;
      s = area + longint'(d);
      area = (s > 64'hFFFF_FFFF) ? 64'(AreaMax) : s;
    endfunction

    function void collapse_test();
      longint va;
      va = (vw > 0 && vh > 0) ? vw * vh : 0;
      if (va > 0 && area * 2 >= longint'(va)) begin
        all_dmg = 1;
        cnt = 0;
      end
    endfunction

    function void merge_into(int i, longint x, y, w, h);
      longint ux, uy, uw, uh;
      bbox(ex[i], ey[i], ew[i], eh[i], x, y, w, h, ux, uy, uw, uh);
      ex[i] = ux; ey[i] = uy; ew[i] = uw; eh[i] = uh;
    endfunction

    function void add_rect(longint x, y, w, h);
      longint wst, best_w;
      int best;
      best = -1;
      best_w = 0;
      if (all_dmg || w <= 0 || h <= 0) return;
      for (int i = 0; i < cnt; i++)
        if (x >= ex[i] && y >= ey[i] && x + w <= ex[i] + ew[i] && y + h <= ey[i] + eh[i])
          return;
      for (int i = 0; i < cnt; i++) begin
        wst = waste(i, x, y, w, h);
        if (wst <= 0) begin
          grow_area(area_of(w, h) + wst);
          merge_into(i, x, y, w, h);
          collapse_test();
          return;
        end
        if (best < 0 || wst < best_w) begin
          best = i;
          best_w = wst;
        end
      end
      if (cnt < Slots) begin
        ex[cnt] = x; ey[cnt] = y; ew[cnt] = w; eh[cnt] = h;
        cnt++;
        grow_area(area_of(w, h));
        collapse_test();
        return;
      end
      if (best >= 0) begin
        grow_area(best_w + area_of(w, h));
        merge_into(best, x, y, w, h);
        collapse_test();
      end
    endfunction

    function void push(longint x, y, w, h, bit valid, bit last);
      dmg_beat_t b;
      b.x = x[15:0]; b.y = y[15:0]; b.w = w[16:0]; b.h = h[16:0];
      b.all_dmg = all_dmg; b.cnt = cnt[3:0]; b.valid = valid; b.last = last;
      pending.push_back(b);
    endfunction

    function void push_bounds();
      longint bx, by, bw, bh, x0, y0, x1, y1, w, h;
      if (all_dmg) begin
        w = vw > 0 ? vw : 0;
        h = vh > 0 ? vh : 0;
        push(vx, vy, w, h, w > 0 && h > 0, 1);
        return;
      end
      if (cnt == 0) begin
        push(0, 0, 0, 0, 0, 1);
        return;
      end
      bx = ex[0]; by = ey[0]; bw = ew[0]; bh = eh[0];
      for (int i = 1; i < cnt; i++)
        bbox(bx, by, bw, bh, ex[i], ey[i], ew[i], eh[i], bx, by, bw, bh);
      x0 = bx > vx ? bx : vx;
      y0 = by > vy ? by : vy;
      x1 = bx + bw;
      if (vx + vw < x1) x1 = vx + vw;
      y1 = by + bh;
      if (vy + vh < y1) y1 = vy + vh;
      if (x1 <= x0 || y1 <= y0) push(0, 0, 0, 0, 0, 1);
      else push(x0, y0, x1 - x0, y1 - y0, 1, 1);
    endfunction

    // Accepted input beat: update the store and queue the results it causes.
    function void note_item(logic [71:0] d);
      opcode_e op;
      op = opcode_e'(d[1:0]);
      case (op)
        OP_CLEAR: begin
          cnt = 0; all_dmg = 0; area = 0;
        end
        OP_ADD: add_rect(longint'($signed(d[17:2])), longint'($signed(d[33:18])),
                         longint'($signed(d[49:34])), longint'($signed(d[65:50])));
        OP_MARK: all_dmg = 1;
        default: begin
          if (cnt == 0) push(0, 0, 0, 0, 0, 1);
          for (int i = 0; i < cnt; i++) push(ex[i], ey[i], ew[i], eh[i], 1, i + 1 == cnt);
          return;
        end
      endcase
      push_bounds();
    endfunction

    function void fail(string what, dmg_beat_t e, dmg_beat_t a);
      string se, sa;
      se = $sformatf("x=%h y=%h w=%h h=%h ad=%b n=%0d v=%b l=%b",
                     e.x, e.y, e.w, e.h, e.all_dmg, e.cnt, e.valid, e.last);
      sa = $sformatf("x=%h y=%h w=%h h=%h ad=%b n=%0d v=%b l=%b",
                     a.x, a.y, a.w, a.h, a.all_dmg, a.cnt, a.valid, a.last);
      if (errors < 10)
        $display("%0t mismatch %s: expected %s, got %s", $realtime, what, se, sa);
      errors++;
    endfunction

    // Accepted output beat: compare with the oldest expectation.
    function void check_beat(logic [71:0] d, logic tl);
      dmg_beat_t a, e;
      a.x = d[15:0]; a.y = d[31:16]; a.w = d[48:32]; a.h = d[65:49];
      a.all_dmg = d[66]; a.cnt = d[70:67]; a.valid = d[71]; a.last = tl;
      if (pending.size() == 0) begin
        e = '0;
        fail("unexpected beat", e, a);
        return;
      end
      e = pending.pop_front();
      if (a.x != e.x) fail("out_x", e, a);
      else if (a.y != e.y) fail("out_y", e, a);
      else if (a.w != e.w) fail("out_w", e, a);
      else if (a.h != e.h) fail("out_h", e, a);
      else if (a.all_dmg != e.all_dmg) fail("all_damaged", e, a);
      else if (a.cnt != e.cnt) fail("rect_count", e, a);
      else if (a.valid != e.valid) fail("rect_valid", e, a);
      else if (a.last != e.last) fail("tlast", e, a);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rect_scoreboard dmg_sb = new();
  int  cycles = 0;
  int  hold_len = 0;   // long receiver hold-off requested by the stimulus
  bit  sink_eager = 0; // receiver always ready while set, once any pending stall has run out

  damage_rect_accumulator_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: both sides sampled at the rising edge.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && s_axis_tvalid && s_axis_tready) dmg_sb.note_item(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) dmg_sb.check_beat(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, a few long, plus the requested hold-off.
  int stall = 0;
  always @(negedge clk_i) begin
    int r;
    if (hold_len > 0) begin
      stall = hold_len;
      hold_len = 0;
    end
    if (stall > 0) begin
      m_axis_tready = 1'b0;
      stall--;
    end else if (sink_eager) begin
      m_axis_tready = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      m_axis_tready = (r < 70);
      if (r >= 95) stall = $urandom_range(10, 40);
      else if (r >= 70) stall = $urandom_range(0, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat; returns at the falling edge after acceptance.
  bit burst = 0;
  task automatic send_item(opcode_e op, logic [15:0] x, y, w, h);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'b0, h, w, y, x, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender idles until every expected beat is back, then lets the block settle.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (dmg_sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [15:0] v);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 4'(idx) << 2;
    pwdata = {{16{v[15]}}, v};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    dmg_sb.set_reg(idx, v);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_viewport(logic [15:0] x, y, w, h);
    drain();
    apb_write(REG_VP_X, x);
    apb_write(REG_VP_Y, y);
    apb_write(REG_VP_W, w);
    apb_write(REG_VP_H, h);
  endtask

  // Random items: mostly adds clustered in a window so that containment and
  // merging happen, some full-range noise, plus lists, clears and marks.
  task automatic random_items(int n, int lo, int span);
    int r, maxd;
    logic [15:0] x, y, w, h;
    maxd = span / 3 > 1 ? span / 3 : 1;
    for (int k = 0; k < n; k++) begin
      if (k % 30 == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      x = 16'(lo + int'($urandom_range(0, span)));
      y = 16'(lo + int'($urandom_range(0, span)));
      w = 16'($urandom_range(1, maxd));
      h = 16'($urandom_range(1, maxd));
      if (dmg_sb.all_dmg && r < 40) send_item(OP_CLEAR, x, y, w, h);
      else if (r < 60) begin
        if ($urandom_range(0, 15) == 0) w = 16'(-int'($urandom_range(0, 5)));
        send_item(OP_ADD, x, y, w, h);
      end else if (r < 72) send_item(OP_LIST, x, y, w, h);
      else if (r < 79) send_item(OP_CLEAR, x, y, w, h);
      else if (r < 83) send_item(OP_MARK, x, y, w, h);
      else send_item(OP_ADD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    burst = 0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part on a 100x80 viewport at the origin.
    set_viewport(16'd0, 16'd0, 16'd100, 16'd80);
    send_item(OP_LIST, 0, 0, 0, 0);                       // empty list
    send_item(OP_ADD, 16'd5, 16'd5, 16'd0, 16'd4);        // zero width
    send_item(OP_ADD, 16'd5, 16'd5, 16'd4, 16'h8000);     // negative height
    send_item(OP_ADD, 16'h8000, 16'h8000, 16'h7FFF, 16'd1);
    send_item(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF); // ignored: all damaged after the previous add
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_ADD, 16'd10, 16'd10, 16'd4, 16'd4);
    send_item(OP_ADD, 16'd11, 16'd11, 16'd2, 16'd2);      // contained: dropped
    send_item(OP_ADD, 16'd14, 16'd10, 16'd4, 16'd4);      // adjacent: zero-waste merge
    for (int i = 0; i < 7; i++)                           // fill all slots
      send_item(OP_ADD, 16'(20 + 10 * i), 16'(40 + 4 * i), 16'd2, 16'd2);
    send_item(OP_ADD, 16'd13, 16'd30, 16'd2, 16'd2);      // full: least-waste merge
    send_item(OP_LIST, 0, 0, 0, 0);
    send_item(OP_MARK, 0, 0, 0, 0);
    send_item(OP_ADD, 16'd1, 16'd1, 16'd3, 16'd3);        // ignored while all damaged
    send_item(OP_LIST, 0, 0, 0, 0);                       // entries kept after mark
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_ADD, 16'd0, 16'd0, 16'd60, 16'd70);      // area collapse
    send_item(OP_LIST, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    random_items(90, -20, 140);

    set_viewport(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    random_items(80, -32768, 65535);

    // Zero-area viewport: collapse never fires.
    set_viewport(16'd10, 16'hFFFB, 16'd0, 16'h8000);
    random_items(80, -40, 200);

    set_viewport(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd5);
    random_items(60, 32600, 160);

    // Long receiver hold-off while the sender keeps offering items.
    set_viewport(16'hFFCE, 16'hFFD8, 16'd400, 16'd300);
    hold_len = 300;
    random_items(40, -60, 460);
    sink_eager = 1;
    random_items(30, -60, 460);
    sink_eager = 0;
    random_items(40, -60, 460);

    drain();
    if (dmg_sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### sim.f
src/dra_pkg.sv
src/damage_rect_accumulator_top.sv
tb/damage_rect_accumulator_top_tb.sv
